[hdl/roqt_pkg.sv]
// Shared types and constants of the rectangle overlap query table.
package roqt_pkg;

	localparam int ID_W         = 5;
	localparam int IN_COORD_W   = 16;
	localparam int IN_SIZE_W    = 15;
	localparam int RESULT_CAP   = 32;
	localparam int HIT_W        = 6;
	localparam int CMP_W        = 7;
	localparam int MAX_RECTS_DEF  = 32;
	localparam int COORD_BITS_DEF = 16;

	typedef enum logic [1:0] {
		REQ_REGISTER = 2'd0,
		REQ_UPDATE   = 2'd1,
		REQ_QUERY    = 2'd2
	} req_kind_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_UNREG = 2'd2
	} resp_status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RESP,
		S_SELF,
		S_SCAN,
		S_FINISH
	} seq_state_t;

endpackage

[hdl/roqt_req_if.sv]
// Request and response channel interfaces of the rectangle overlap query table.
interface roqt_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  req_type;
	logic [4:0]  entry_id;
	logic signed [15:0] pos_x;
	logic signed [15:0] pos_y;
	logic [14:0] width;
	logic [14:0] height;
	logic        active;

	modport source (output valid, req_type, entry_id, pos_x, pos_y, width, height, active,
		input ready);
	modport sink (input valid, req_type, entry_id, pos_x, pos_y, width, height, active,
		output ready);
endinterface

interface roqt_resp_if;
	logic       valid;
	logic       ready;
	logic [1:0] resp_kind;
	logic [4:0] result_id;
	logic       hit_valid;
	logic [1:0] status;
	logic       last;

	modport source (output valid, resp_kind, result_id, hit_valid, status, last,
		input ready);
	modport sink (input valid, resp_kind, result_id, hit_valid, status, last,
		output ready);
endinterface

[hdl/rect_overlap_query_table.sv]
// Top level of the rectangle overlap query table with its sequencer and entry memory.
//
//  channel | dir | contents
//  --------+-----+-------------------------------------------------------------
//  req     | in  | register, update or query item with rectangle fields
//  resp    | out | one item per register/update, per overlap hit or one for no hit
//
// Register, update and rejected items are accepted, then the response item is
// loaded into the output register. A query is accepted, the queried entry is
// read, then the entries are scanned in index order, since the single read port
// of the entry memory and the one overlap compare unit visit one entry per cycle
// while the output does not stall, and a final state sends the closing item.
// Reset clears the entry count and the sequencer; the entry memory needs no
// clearing because only entries below the count are ever used. A stalled
// output holds the scan whenever a second hit must leave while one still waits.
module rect_overlap_query_table #(
	parameter int MAX_RECTS  = roqt_pkg::MAX_RECTS_DEF,
	parameter int COORD_BITS = roqt_pkg::COORD_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	roqt_req_if.sink    req,
	roqt_resp_if.source resp
);
	import roqt_pkg::*;

	localparam int IDX_W = (MAX_RECTS > 2) ? $clog2(MAX_RECTS) : 1;
	localparam int CNT_W = $clog2(MAX_RECTS + 1);
	localparam int CB    = COORD_BITS;

	// Entry memory: one row per rectangle, one write and one read port.
	logic signed [CB-1:0] mem_left   [MAX_RECTS];
	logic signed [CB-1:0] mem_bottom [MAX_RECTS];
	logic [CB-2:0]        mem_width  [MAX_RECTS];
	logic [CB-2:0]        mem_height [MAX_RECTS];
	logic                 mem_active [MAX_RECTS];

	logic signed [CB-1:0] rd_left_q, rd_bottom_q;
	logic [CB-2:0]        rd_width_q, rd_height_q;
	logic                 rd_active_q;

	seq_state_t state_q, state_d;
	logic [CNT_W-1:0] count_q;
	logic [1:0]       kind_q;
	logic [ID_W-1:0]  id_q;
	logic [ID_W-1:0]  resp_id_q;
	resp_status_t     resp_st_q;

	// The queried rectangle, with its right and top edges formed once.
	logic signed [CB-1:0] self_left_q, self_bottom_q;
	logic signed [CB:0]   self_right_q, self_top_q;

	logic [IDX_W-1:0] cmp_idx_q;
	logic             hold_vld_q;
	logic [IDX_W-1:0] hold_idx_q;
	logic [HIT_W-1:0] found_q;

	logic             out_vld_q;
	logic [1:0]       out_kind_q;
	logic [ID_W-1:0]  out_id_q;
	logic             out_hit_q;
	logic [1:0]       out_st_q;
	logic             out_last_q;

	logic accept, slot_free, id_ok, table_full;
	logic mem_we;
	logic [IDX_W-1:0] mem_waddr;
	logic signed [CB-1:0] in_left, in_bottom;
	logic [CB-2:0] in_width, in_height;
	logic [31:0] px_ext, py_ext, w_ext, h_ext;

	logic rd_en;
	logic [IDX_W-1:0] rd_addr;
	logic latch_self, scan_go, cand_hit, stall, at_end;
	logic signed [CB:0] cand_right, cand_top, cand_left_x, cand_bottom_x;
	logic signed [CB:0] self_left_x, self_bottom_x;

	logic            push;
	logic [1:0]      push_kind;
	logic [ID_W-1:0] push_id;
	logic            push_hit;
	logic [1:0]      push_st;
	logic            push_last;

	assign req.ready  = (state_q == S_IDLE);
	assign accept     = req.valid && req.ready;
	assign slot_free  = !out_vld_q || resp.ready;
	assign id_ok      = {2'b00, req.entry_id} < CMP_W'(count_q);
	assign table_full = (count_q == CNT_W'(MAX_RECTS));

	// Positions keep their low COORD_BITS bits; sizes their low COORD_BITS-1 bits.
	assign px_ext    = {{16{req.pos_x[15]}}, req.pos_x};
	assign py_ext    = {{16{req.pos_y[15]}}, req.pos_y};
	assign w_ext     = {17'd0, req.width};
	assign h_ext     = {17'd0, req.height};
	assign in_left   = px_ext[CB-1:0];
	assign in_bottom = py_ext[CB-1:0];
	assign in_width  = w_ext[CB-2:0];
	assign in_height = h_ext[CB-2:0];

	assign mem_we = accept && (((req.req_type == REQ_REGISTER) && !table_full) ||
		((req.req_type == REQ_UPDATE) && id_ok));
	assign mem_waddr = (req.req_type == REQ_REGISTER) ? IDX_W'(count_q) : IDX_W'(req.entry_id);

	// Inclusive overlap of the queried rectangle with the entry just read.
	assign cand_left_x   = {rd_left_q[CB-1], rd_left_q};
	assign cand_bottom_x = {rd_bottom_q[CB-1], rd_bottom_q};
	assign cand_right    = cand_left_x + $signed({2'b00, rd_width_q});
	assign cand_top      = cand_bottom_x + $signed({2'b00, rd_height_q});
	assign self_left_x   = {self_left_q[CB-1], self_left_q};
	assign self_bottom_x = {self_bottom_q[CB-1], self_bottom_q};

	assign cand_hit = (CMP_W'(cmp_idx_q) != CMP_W'(id_q)) && rd_active_q &&
		(self_left_x <= cand_right) && (cand_left_x <= self_right_q) &&
		(self_bottom_x <= cand_top) && (cand_bottom_x <= self_top_q);

	// A new hit releases the held one; that needs a free output slot.
	assign stall  = cand_hit && hold_vld_q && !slot_free;
	assign at_end = ((CNT_W'(cmp_idx_q) + CNT_W'(1)) == count_q) ||
		(cand_hit && ((found_q + HIT_W'(1)) == HIT_W'(RESULT_CAP)));

	always_comb begin
		state_d    = state_q;
		rd_en      = 1'b0;
		rd_addr    = cmp_idx_q + IDX_W'(1);
		latch_self = 1'b0;
		scan_go    = 1'b0;
		push       = 1'b0;
		push_kind  = kind_q;
		push_id    = resp_id_q;
		push_hit   = 1'b0;
		push_st    = resp_st_q;
		push_last  = 1'b1;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (req.req_type)
						REQ_REGISTER, REQ_UPDATE: state_d = S_RESP;
						REQ_QUERY: begin
							state_d = id_ok ? S_SELF : S_RESP;
							rd_en   = 1'b1;
							rd_addr = IDX_W'(req.entry_id);
						end
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_RESP: begin
				if (slot_free) begin
					push    = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_SELF: begin
				latch_self = 1'b1;
				rd_en      = 1'b1;
				rd_addr    = '0;
				state_d    = S_SCAN;
			end
			S_SCAN: begin
				if (!stall) begin
					scan_go = 1'b1;
					if (cand_hit && hold_vld_q) begin
						push      = 1'b1;
						push_kind = REQ_QUERY;
						push_id   = ID_W'(hold_idx_q);
						push_hit  = 1'b1;
						push_st   = ST_OK;
						push_last = 1'b0;
					end
					if (at_end) begin
						state_d = S_FINISH;
					end else begin
						rd_en = 1'b1;
					end
				end
			end
			S_FINISH: begin
				if (slot_free) begin
					push      = 1'b1;
					push_kind = REQ_QUERY;
					push_id   = hold_vld_q ? ID_W'(hold_idx_q) : '0;
					push_hit  = hold_vld_q;
					push_st   = ST_OK;
					state_d   = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			out_vld_q  <= 1'b0;
			hold_vld_q <= 1'b0;
			found_q    <= '0;
		end else begin
			if (accept && (req.req_type == REQ_REGISTER) && !table_full) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (push) begin
				out_vld_q <= 1'b1;
			end else if (resp.ready) begin
				out_vld_q <= 1'b0;
			end
			if (latch_self) begin
				hold_vld_q <= 1'b0;
				found_q    <= '0;
			end else if (scan_go && cand_hit) begin
				hold_vld_q <= 1'b1;
				found_q    <= found_q + HIT_W'(1);
			end else if (state_q == S_FINISH && slot_free) begin
				hold_vld_q <= 1'b0;
			end
		end
	end

	// Request capture, scan position and output payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= req.req_type;
			id_q   <= req.entry_id;
			case (req.req_type)
				REQ_REGISTER: begin
					resp_id_q <= table_full ? '0 : ID_W'(count_q);
					resp_st_q <= table_full ? ST_FULL : ST_OK;
				end
				default: begin
					resp_id_q <= id_ok ? req.entry_id : '0;
					resp_st_q <= id_ok ? ST_OK : ST_UNREG;
				end
			endcase
		end
		if (latch_self) begin
			self_left_q   <= rd_left_q;
			self_bottom_q <= rd_bottom_q;
			self_right_q  <= {rd_left_q[CB-1], rd_left_q} + $signed({2'b00, rd_width_q});
			self_top_q    <= {rd_bottom_q[CB-1], rd_bottom_q} + $signed({2'b00, rd_height_q});
			cmp_idx_q     <= '0;
		end else if (scan_go) begin
			cmp_idx_q <= cmp_idx_q + IDX_W'(1);
			if (cand_hit) begin
				hold_idx_q <= cmp_idx_q;
			end
		end
		if (push) begin
			out_kind_q <= push_kind;
			out_id_q   <= push_id;
			out_hit_q  <= push_hit;
			out_st_q   <= push_st;
			out_last_q <= push_last;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_left[mem_waddr]   <= in_left;
			mem_bottom[mem_waddr] <= in_bottom;
			mem_width[mem_waddr]  <= in_width;
			mem_height[mem_waddr] <= in_height;
			mem_active[mem_waddr] <= req.active;
		end
		if (rd_en) begin
			rd_left_q   <= mem_left[rd_addr];
			rd_bottom_q <= mem_bottom[rd_addr];
			rd_width_q  <= mem_width[rd_addr];
			rd_height_q <= mem_height[rd_addr];
			rd_active_q <= mem_active[rd_addr];
		end
	end

	assign resp.valid     = out_vld_q;
	assign resp.resp_kind = out_kind_q;
	assign resp.result_id = out_id_q;
	assign resp.hit_valid = out_hit_q;
	assign resp.status    = out_st_q;
	assign resp.last      = out_last_q;

	// The entry count never passes the table size.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		CMP_W'(count_q) <= CMP_W'(MAX_RECTS))
		else $error("entry count beyond table size");

	// No hit is held over once the sequencer is back at rest.
	a_hold_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !hold_vld_q)
		else $error("held hit left behind after query");

	// The number of hits of one query stays within the result cap.
	a_found_cap: assert property (@(posedge clk) disable iff (!arst_n)
		found_q <= HIT_W'(RESULT_CAP))
		else $error("hit count beyond result cap");

	// Items released during the scan are hits and never close the query.
	a_scan_push: assert property (@(posedge clk) disable iff (!arst_n)
		(push && state_q == S_SCAN) |=> (resp.valid && resp.hit_valid && !resp.last))
		else $error("scan released a malformed item");

	// Leaving a query always presents its closing item.
	a_finish_last: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FINISH && state_d == S_IDLE) |=> (resp.valid && resp.last))
		else $error("query ended without a last item");

endmodule

[test/testbench.sv]
// Self-checking testbench of the rectangle overlap query table: directed table, then random traffic.
`timescale 1ns / 1ps

module testbench;

	import roqt_pkg::*;

	// The request kind that the block ignores has no member in the package enum.
	localparam logic [1:0] REQ_UNUSED = 2'd3;

	localparam int TABLE_DEPTH = MAX_RECTS_DEF;

	// The longest quiet stretch of a correct run is the deliberate hold-off of the
	// response side. A full query scan with every hit stalled is far shorter than that.
	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 2000;
	// A query scans each table entry once, so this tail is ample.
	localparam int TAIL_CYCLES    = 64;
	localparam int RANDOM_ITEMS   = 450;
	localparam int REPORT_LIMIT   = 10;

	// One request item as the testbench sees it.
	typedef struct packed {
		logic [1:0]         kind;
		logic [4:0]         id;
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic [14:0]        w;
		logic [14:0]        h;
		logic               act;
	} rect_req_t;

	// One response item.
	typedef struct packed {
		logic [1:0] kind;
		logic [4:0] id;
		logic       hit;
		logic [1:0] status;
		logic       last;
	} table_resp_t;

	// A row of the directed table. Where typed is set, the expected response is the
	// one written in the row, or none at all when silent is set.
	typedef struct packed {
		rect_req_t   req;
		logic        typed;
		logic        silent;
		table_resp_t exp;
	} dir_row_t;

	localparam table_resp_t NO_RESP = '0;

	localparam int DIR_COUNT = 23;

	localparam dir_row_t DIR_ROWS [DIR_COUNT] = '{
		// Empty table: query and update are rejected, the unused kind is dropped.
		'{'{REQ_QUERY, 5'd0, 16'sd0, 16'sd0, 15'd0, 15'd0, 1'b0},
			1'b1, 1'b0, '{REQ_QUERY, 5'd0, 1'b0, ST_UNREG, 1'b1}},
		'{'{REQ_UPDATE, 5'd0, 16'sd5, 16'sd5, 15'd5, 15'd5, 1'b1},
			1'b1, 1'b0, '{REQ_UPDATE, 5'd0, 1'b0, ST_UNREG, 1'b1}},
		'{'{REQ_UNUSED, 5'd0, 16'sd0, 16'sd0, 15'd0, 15'd0, 1'b0},
			1'b1, 1'b1, NO_RESP},
		// Most negative corner with the largest size, then a point at the far corner.
		'{'{REQ_REGISTER, 5'd0, 16'sh8000, 16'sh8000, 15'h7FFF, 15'h7FFF, 1'b1},
			1'b1, 1'b0, '{REQ_REGISTER, 5'd0, 1'b0, ST_OK, 1'b1}},
		'{'{REQ_REGISTER, 5'd0, 16'sh7FFF, 16'sh7FFF, 15'd0, 15'd0, 1'b1},
			1'b1, 1'b0, '{REQ_REGISTER, 5'd1, 1'b0, ST_OK, 1'b1}},
		'{'{REQ_REGISTER, 5'd0, 16'sd0, 16'sd0, 15'd0, 15'd0, 1'b0},
			1'b1, 1'b0, '{REQ_REGISTER, 5'd2, 1'b0, ST_OK, 1'b1}},
		// No hits here, and the inactive queried entry still runs its query.
		'{'{REQ_QUERY, 5'd0, 16'sd0, 16'sd0, 15'd0, 15'd0, 1'b0},
			1'b0, 1'b0, NO_RESP},
		'{'{REQ_QUERY, 5'd2, 16'sd0, 16'sd0, 15'd0, 15'd0, 1'b0},
			1'b0, 1'b0, NO_RESP},
		// Move entry 2 onto the top right corner of entry 0: touching corners overlap.
		'{'{REQ_UPDATE, 5'd2, -16'sd1, -16'sd1, 15'd0, 15'd0, 1'b1},
			1'b1, 1'b0, '{REQ_UPDATE, 5'd2, 1'b0, ST_OK, 1'b1}},
		'{'{REQ_QUERY, 5'd0, 16'sd0, 16'sd0, 15'd0, 15'd0, 1'b0},
			1'b0, 1'b0, NO_RESP},
		'{'{REQ_QUERY, 5'd1, 16'sd0, 16'sd0, 15'd0, 15'd0, 1'b0},
			1'b0, 1'b0, NO_RESP},
		// Highest id, far above the entry count.
		'{'{REQ_UPDATE, 5'd31, 16'sd1, 16'sd1, 15'd1, 15'd1, 1'b1},
			1'b1, 1'b0, '{REQ_UPDATE, 5'd0, 1'b0, ST_UNREG, 1'b1}},
		'{'{REQ_QUERY, 5'd31, 16'sd0, 16'sd0, 15'd0, 15'd0, 1'b0},
			1'b1, 1'b0, '{REQ_QUERY, 5'd0, 1'b0, ST_UNREG, 1'b1}},
		// A vertical and a horizontal bar that cross with no corner inside the other.
		// The entry id of a register item is ignored.
		'{'{REQ_REGISTER, 5'd31, -16'sd100, -16'sd1000, 15'd200, 15'd2000, 1'b1},
			1'b1, 1'b0, '{REQ_REGISTER, 5'd3, 1'b0, ST_OK, 1'b1}},
		'{'{REQ_REGISTER, 5'd0, -16'sd1000, -16'sd100, 15'd2000, 15'd200, 1'b1},
			1'b1, 1'b0, '{REQ_REGISTER, 5'd4, 1'b0, ST_OK, 1'b1}},
		'{'{REQ_QUERY, 5'd3, 16'sd0, 16'sd0, 15'd0, 15'd0, 1'b0},
			1'b0, 1'b0, NO_RESP},
		// An inactive entry is skipped as a candidate but may be queried itself.
		'{'{REQ_UPDATE, 5'd1, -16'sd50, -16'sd50, 15'd100, 15'd100, 1'b0},
			1'b1, 1'b0, '{REQ_UPDATE, 5'd1, 1'b0, ST_OK, 1'b1}},
		'{'{REQ_QUERY, 5'd1, 16'sd0, 16'sd0, 15'd0, 15'd0, 1'b0},
			1'b0, 1'b0, NO_RESP},
		'{'{REQ_QUERY, 5'd4, 16'sd0, 16'sd0, 15'd0, 15'd0, 1'b0},
			1'b0, 1'b0, NO_RESP},
		// The first id at the entry count is not registered.
		'{'{REQ_QUERY, 5'd5, 16'sd0, 16'sd0, 15'd0, 15'd0, 1'b0},
			1'b1, 1'b0, '{REQ_QUERY, 5'd0, 1'b0, ST_UNREG, 1'b1}},
		// The last registered entry gets the far right edge and a zero height.
		'{'{REQ_UPDATE, 5'd4, 16'sh7FFF, 16'sh8000, 15'h7FFF, 15'd0, 1'b1},
			1'b1, 1'b0, '{REQ_UPDATE, 5'd4, 1'b0, ST_OK, 1'b1}},
		'{'{REQ_UNUSED, 5'd31, 16'shFFFF, 16'shFFFF, 15'h7FFF, 15'h7FFF, 1'b1},
			1'b1, 1'b1, NO_RESP},
		'{'{REQ_QUERY, 5'd0, 16'sd0, 16'sd0, 15'd0, 15'd0, 1'b0},
			1'b0, 1'b0, NO_RESP}
	};

	logic clk;
	logic arst_n;

	roqt_req_if  req_ch ();
	roqt_resp_if resp_ch ();

	rect_overlap_query_table DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.resp   (resp_ch)
	);

	// Shadow copy of the rectangle table, updated as each request item is accepted.
	logic signed [15:0] tbl_left   [TABLE_DEPTH];
	logic signed [15:0] tbl_bottom [TABLE_DEPTH];
	logic [14:0]        tbl_width  [TABLE_DEPTH];
	logic [14:0]        tbl_height [TABLE_DEPTH];
	logic               tbl_active [TABLE_DEPTH];
	int                 tbl_count = 0;

	// Responses predicted for the item just accepted, and all responses still awaited.
	table_resp_t fresh_q [$];
	table_resp_t awaited_q [$];

	int fail_count = 0;

	// Flags through which the stimulus process steers idling on both sides.
	bit sender_gaps_on     = 1'b1;
	bit receiver_stalls_on = 1'b1;
	bit resp_hold_req      = 1'b0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic void note_failure(input string msg);
		fail_count++;
		if (fail_count <= REPORT_LIMIT)
			$display("ERROR at %0t: %s", $realtime, msg);
	endfunction

	function automatic table_resp_t make_resp(input logic [1:0] kind, input logic [4:0] id,
			input logic hit, input logic [1:0] status, input logic last);
		table_resp_t r;
		r.kind   = kind;
		r.id     = id;
		r.hit    = hit;
		r.status = status;
		r.last   = last;
		return r;
	endfunction

	function automatic void store_rect(input int idx, input rect_req_t r);
		tbl_left[idx]   = r.x;
		tbl_bottom[idx] = r.y;
		tbl_width[idx]  = r.w;
		tbl_height[idx] = r.h;
		tbl_active[idx] = r.act;
	endfunction

	// Inclusive test: edges that only touch count as an overlap. The sums are formed
	// as int, so a right or top edge beyond the 16-bit range is still exact.
	function automatic bit rects_overlap(input int a, input int b);
		int a_right;
		int b_right;
		int a_top;
		int b_top;
		a_right = int'(tbl_left[a]) + int'(tbl_width[a]);
		b_right = int'(tbl_left[b]) + int'(tbl_width[b]);
		a_top   = int'(tbl_bottom[a]) + int'(tbl_height[a]);
		b_top   = int'(tbl_bottom[b]) + int'(tbl_height[b]);
		return (int'(tbl_left[a]) <= b_right) && (int'(tbl_left[b]) <= a_right) &&
			(int'(tbl_bottom[a]) <= b_top) && (int'(tbl_bottom[b]) <= a_top);
	endfunction

	// Applies one accepted request to the shadow table and leaves its responses in
	// fresh_q, in the order the block must send them.
	function automatic void predict_table_access(input rect_req_t r);
		int hits;
		fresh_q.delete();
		if (r.kind == REQ_REGISTER) begin
			if (tbl_count >= TABLE_DEPTH) begin
				fresh_q.insert(fresh_q.size(),
					make_resp(REQ_REGISTER, 5'd0, 1'b0, ST_FULL, 1'b1));
			end else begin
				store_rect(tbl_count, r);
				fresh_q.insert(fresh_q.size(),
					make_resp(REQ_REGISTER, 5'(tbl_count), 1'b0, ST_OK, 1'b1));
				tbl_count++;
			end
		end else if (r.kind == REQ_UNUSED) begin
			// Dropped without a response.
		end else if (int'(r.id) >= tbl_count) begin
			fresh_q.insert(fresh_q.size(), make_resp(r.kind, 5'd0, 1'b0, ST_UNREG, 1'b1));
		end else if (r.kind == REQ_UPDATE) begin
			store_rect(int'(r.id), r);
			fresh_q.insert(fresh_q.size(), make_resp(REQ_UPDATE, r.id, 1'b0, ST_OK, 1'b1));
		end else begin
			// Query: the stored entry is compared with every other active entry in
			// index order, and its own active flag does not matter.
			hits = 0;
			for (int i = 0; i < tbl_count && hits < RESULT_CAP; i++) begin
				if (i != int'(r.id) && tbl_active[i] && rects_overlap(int'(r.id), i)) begin
					fresh_q.insert(fresh_q.size(),
						make_resp(REQ_QUERY, 5'(i), 1'b1, ST_OK, 1'b0));
					hits++;
				end
			end
			if (hits == 0)
				fresh_q.insert(fresh_q.size(), make_resp(REQ_QUERY, 5'd0, 1'b0, ST_OK, 1'b1));
			else
				fresh_q[hits - 1].last = 1'b1;
		end
	endfunction

	function automatic logic [15:0] extreme_coord();
		case ($urandom_range(0, 3))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			default: return 16'hFFFF;
		endcase
	endfunction

	function automatic logic [14:0] extreme_size();
		case ($urandom_range(0, 3))
			0: return 15'h0000;
			1: return 15'h7FFF;
			2: return 15'h0001;
			default: return 15'h7FFE;
		endcase
	endfunction

	// Builds a random request. Half of the rectangles fall into a small cluster so
	// that queries find many hits, some span the whole coordinate range, some sit on
	// the extremes, and some are placed exactly on the right edge of a stored entry.
	function automatic rect_req_t random_request(input logic [1:0] kind);
		rect_req_t r;
		int mode;
		int j;
		r.kind = kind;
		r.id   = 5'($urandom_range(0, 31));
		r.act  = ($urandom_range(0, 9) < 8);
		r.x    = 16'(int'($urandom_range(0, 4095)) - 2048);
		r.y    = 16'(int'($urandom_range(0, 4095)) - 2048);
		r.w    = 15'($urandom_range(0, 1200));
		r.h    = 15'($urandom_range(0, 1200));
		mode   = $urandom_range(0, 99);
		if (mode >= 50 && mode < 70) begin
			r.x = 16'($urandom());
			r.y = 16'($urandom());
			r.w = 15'($urandom());
			r.h = 15'($urandom());
		end else if (mode >= 70 && mode < 85) begin
			r.x = extreme_coord();
			r.y = extreme_coord();
			r.w = extreme_size();
			r.h = extreme_size();
		end else if (mode >= 85 && tbl_count > 0) begin
			j   = $urandom_range(0, tbl_count - 1);
			r.x = 16'(int'(tbl_left[j]) + int'(tbl_width[j]));
			r.y = tbl_bottom[j];
			r.w = 15'($urandom_range(0, 600));
			r.h = 15'($urandom_range(0, 600));
		end
		return r;
	endfunction

	function automatic logic [1:0] pick_kind(input int reg_pct, input int query_pct,
			input int update_pct);
		int p;
		p = $urandom_range(0, 99);
		if (p < reg_pct)
			return REQ_REGISTER;
		if (p < reg_pct + query_pct)
			return REQ_QUERY;
		if (p < reg_pct + query_pct + update_pct)
			return REQ_UPDATE;
		return REQ_UNUSED;
	endfunction

	// Offers one request item, after a random gap when gaps are enabled, and returns
	// at the clock edge that accepts it. Valid stays high on return, so a following
	// item with no gap keeps it high without a glitch. The responses of the item are
	// then predicted, or taken from the directed row when it has them typed in.
	task automatic issue(input rect_req_t r, input bit typed, input bit silent,
			input table_resp_t exp);
		int gap;
		gap = sender_gaps_on ? $urandom_range(0, 4) : 0;
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid    <= 1'b1;
		req_ch.req_type <= r.kind;
		req_ch.entry_id <= r.id;
		req_ch.pos_x    <= r.x;
		req_ch.pos_y    <= r.y;
		req_ch.width    <= r.w;
		req_ch.height   <= r.h;
		req_ch.active   <= r.act;
		@(posedge clk);
		while (req_ch.ready !== 1'b1)
			@(posedge clk);
		predict_table_access(r);
		if (typed) begin
			if (!silent)
				awaited_q.insert(awaited_q.size(), exp);
		end else begin
			foreach (fresh_q[m])
				awaited_q.insert(awaited_q.size(), fresh_q[m]);
		end
	endtask

	// Response side: before each item it draws a stall, or serves a long hold-off when
	// asked for one. Fields are read at the accepting edge, before any update of that
	// edge lands, and compared with the oldest awaited response.
	initial begin : resp_sink
		table_resp_t got;
		table_resp_t want;
		int hold;
		resp_ch.ready <= 1'b0;
		@(posedge clk);
		forever begin
			if (resp_hold_req) begin
				hold = HOLD_CYCLES;
				resp_hold_req = 1'b0;
			end else begin
				hold = receiver_stalls_on ? $urandom_range(0, 4) : 0;
			end
			if (hold > 0) begin
				resp_ch.ready <= 1'b0;
				repeat (hold) @(posedge clk);
			end
			resp_ch.ready <= 1'b1;
			@(posedge clk);
			while (resp_ch.valid !== 1'b1)
				@(posedge clk);
			got = make_resp(resp_ch.resp_kind, resp_ch.result_id, resp_ch.hit_valid,
				resp_ch.status, resp_ch.last);
			if (awaited_q.size() == 0) begin
				note_failure($sformatf({"response with none awaited: ",
					"kind=%0d id=%0d hit=%0d status=%0d last=%0d"},
					got.kind, got.id, got.hit, got.status, got.last));
			end else begin
				want = awaited_q.pop_front();
				if (got !== want)
					note_failure($sformatf({"expected kind=%0d id=%0d hit=%0d status=%0d last=%0d, ",
						"got kind=%0d id=%0d hit=%0d status=%0d last=%0d"},
						want.kind, want.id, want.hit, want.status, want.last,
						got.kind, got.id, got.hit, got.status, got.last));
			end
		end
	end

	// Ends the run when neither channel has moved an item for too long.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
					(resp_ch.valid === 1'b1 && resp_ch.ready === 1'b1))
				quiet = 0;
			else
				quiet++;
		end
		$display("ERROR: no item moved for %0d cycles", WATCHDOG_LIMIT);
		$display("CHECK FAILED");
		$finish;
	end

	initial begin : stimulus
		int n_random;
		int n_steps;
		int full_rejects;
		int guard;
		logic [1:0] kind;

		arst_n          <= 1'b0;
		req_ch.valid    <= 1'b0;
		req_ch.req_type <= REQ_REGISTER;
		req_ch.entry_id <= 5'd0;
		req_ch.pos_x    <= 16'sd0;
		req_ch.pos_y    <= 16'sd0;
		req_ch.width    <= 15'd0;
		req_ch.height   <= 15'd0;
		req_ch.active   <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: walk the table in order.
		for (int k = 0; k < DIR_COUNT; k++)
			issue(DIR_ROWS[k].req, DIR_ROWS[k].typed, DIR_ROWS[k].silent, DIR_ROWS[k].exp);

		// Fill the table, mostly with registrations, mixed with updates and queries of
		// ids that may not be registered yet. Keep going until a few registrations
		// have bounced off the full table. Every item sent counts toward the total.
		n_random     = DIR_COUNT;
		full_rejects = 0;
		guard        = 0;
		while ((tbl_count < TABLE_DEPTH || full_rejects < 4) && guard < 300) begin
			kind = pick_kind(65, 15, 12);
			if (kind == REQ_REGISTER && tbl_count >= TABLE_DEPTH)
				full_rejects++;
			issue(random_request(kind), 1'b0, 1'b0, NO_RESP);
			n_random++;
			guard++;
		end

		// Back-pressure: the response side holds off for a long stretch while queries
		// keep coming back to back, so the block must stall its request side.
		sender_gaps_on = 1'b0;
		resp_hold_req  = 1'b1;
		repeat (24) begin
			issue(random_request(REQ_QUERY), 1'b0, 1'b0, NO_RESP);
			n_random++;
		end

		// Let the block drain completely before the next burst.
		req_ch.valid <= 1'b0;
		while (awaited_q.size() != 0)
			@(posedge clk);
		sender_gaps_on = 1'b1;

		// Main mix on the full table. Every fifty items the idling pattern changes, so
		// both sides spend stretches with gaps, with stalls, with both and with neither.
		n_steps = 0;
		while (n_random < RANDOM_ITEMS) begin
			if (n_steps % 50 == 0) begin
				sender_gaps_on     = ((n_steps / 50) % 4) inside {0, 1};
				receiver_stalls_on = ((n_steps / 50) % 4) inside {0, 2};
			end
			kind = pick_kind(10, 45, 38);
			issue(random_request(kind), 1'b0, 1'b0, NO_RESP);
			n_random++;
			n_steps++;
		end

		// Drain, then watch a little longer for responses that should not come.
		req_ch.valid <= 1'b0;
		while (awaited_q.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (fail_count == 0 && awaited_q.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
